// ----- sv/arb_pkg.sv -----
// Shared types and constants for the affine rectangle bounds accumulator.
// No dependencies; imported by arb_corner_eval and affine_rect_bounds_accumulator.

package arb_pkg;

  // Field widths of one map item and of one result item.
  localparam int RECT_FIELD_W      = 16;
  localparam int COEF_W            = 32;
  localparam int COORD_W           = 64;
  localparam int DEFAULT_RECT_BITS = 16;

  // Stream payload widths (fields packed from bit 0 up, whole bytes).
  localparam int IN_DATA_W  = 4 * RECT_FIELD_W + 2 * COORD_W + 4 * COEF_W;
  localparam int OUT_DATA_W = 4 * COORD_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 2;

  // Bit positions inside the tuser groups.
  localparam int IN_USER_FIRST    = 0;
  localparam int IN_USER_VISIBLE  = 1;
  localparam int OUT_USER_SEEN    = 0;
  localparam int OUT_USER_SAT     = 1;

  // Saturation limits of a signed coordinate.
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Per-item flags that travel down the pipeline beside the data.
  typedef struct packed {
    logic first_map;
    logic visible;
  } arb_tag_t;

endpackage

// ----- sv/arb_corner_eval.sv -----
// Two-stage affine evaluation of the four rectangle corners (products, then
// saturating origin sums). Depends on arb_pkg.

module arb_corner_eval import arb_pkg::*; #(
  parameter int CB = DEFAULT_RECT_BITS + 1
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [CB-1:0]               col0,
  input  logic [CB-1:0]               col1,
  input  logic [CB-1:0]               row0,
  input  logic [CB-1:0]               row1,
  input  logic signed [COORD_W-1:0]   origin_x,
  input  logic signed [COEF_W-1:0]    x_per_col,
  input  logic signed [COEF_W-1:0]    x_per_row,
  input  logic signed [COORD_W-1:0]   origin_y,
  input  logic signed [COEF_W-1:0]    y_per_col,
  input  logic signed [COEF_W-1:0]    y_per_row,
  output logic signed [COORD_W-1:0]   gx [4],
  output logic signed [COORD_W-1:0]   gy [4],
  output logic                        sat
);

  // Product width: unsigned coordinate made signed, times a coefficient.
  localparam int PW = CB + 1 + COEF_W;
  // Width of the sum of a column and a row product.
  localparam int SW = PW + 1;
  localparam int EW = COORD_W + 1;

  logic signed [CB:0]         cs [2];
  logic signed [CB:0]         rs [2];
  logic signed [PW-1:0]       pxc_nxt [2];
  logic signed [PW-1:0]       pxr_nxt [2];
  logic signed [PW-1:0]       pyc_nxt [2];
  logic signed [PW-1:0]       pyr_nxt [2];
  logic signed [PW-1:0]       pxc_r [2];
  logic signed [PW-1:0]       pxr_r [2];
  logic signed [PW-1:0]       pyc_r [2];
  logic signed [PW-1:0]       pyr_r [2];
  logic signed [COORD_W-1:0]  ox_r;
  logic signed [COORD_W-1:0]  oy_r;
  logic signed [COORD_W-1:0]  gx_nxt [4];
  logic signed [COORD_W-1:0]  gy_nxt [4];
  logic [3:0]                 satx;
  logic [3:0]                 saty;
  logic                       sat_nxt;

  // Column and row values as non-negative signed operands.
  assign cs[0] = $signed({1'b0, col0});
  assign cs[1] = $signed({1'b0, col1});
  assign rs[0] = $signed({1'b0, row0});
  assign rs[1] = $signed({1'b0, row1});

  // Eight independent products; exact at PW bits.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pxc_nxt[i] = PW'(cs[i]) * PW'(x_per_col);
      pxr_nxt[i] = PW'(rs[i]) * PW'(x_per_row);
      pyc_nxt[i] = PW'(cs[i]) * PW'(y_per_col);
      pyr_nxt[i] = PW'(rs[i]) * PW'(y_per_row);
    end
  end

  // Product stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      pxc_r <= pxc_nxt;
      pxr_r <= pxr_nxt;
      pyc_r <= pyc_nxt;
      pyr_r <= pyr_nxt;
      ox_r  <= origin_x;
      oy_r  <= origin_y;
    end
  end

  // Corner k uses column (k bit 0) and row (k bit 1). Only the origin
  // addition can leave the signed range; it is clamped there.
  always_comb begin
    logic signed [SW-1:0] px;
    logic signed [SW-1:0] py;
    logic signed [EW-1:0] sx;
    logic signed [EW-1:0] sy;
    for (int k = 0; k < 4; k++) begin
      px = {pxc_r[k % 2][PW-1], pxc_r[k % 2]} + {pxr_r[k / 2][PW-1], pxr_r[k / 2]};
      py = {pyc_r[k % 2][PW-1], pyc_r[k % 2]} + {pyr_r[k / 2][PW-1], pyr_r[k / 2]};
      sx = {ox_r[COORD_W-1], ox_r} + {{(EW-SW){px[SW-1]}}, px};
      sy = {oy_r[COORD_W-1], oy_r} + {{(EW-SW){py[SW-1]}}, py};
      satx[k] = sx[EW-1] ^ sx[EW-2];
      saty[k] = sy[EW-1] ^ sy[EW-2];
      if (satx[k]) begin
        gx_nxt[k] = sx[EW-1] ? COORD_MIN : COORD_MAX;
      end else begin
        gx_nxt[k] = sx[COORD_W-1:0];
      end
      if (saty[k]) begin
        gy_nxt[k] = sy[EW-1] ? COORD_MIN : COORD_MAX;
      end else begin
        gy_nxt[k] = sy[COORD_W-1:0];
      end
    end
  end

  assign sat_nxt = |{satx, saty};

  // Corner stage register.
  always_ff @(posedge clk) begin
    if (en) begin
      gx  <= gx_nxt;
      gy  <= gy_nxt;
      sat <= sat_nxt;
    end
  end

endmodule

// ----- sv/affine_rect_bounds_accumulator.sv -----
// Top level of the affine rectangle bounds accumulator: stream ports,
// pipeline control and the running bounds. Depends on arb_pkg, arb_corner_eval.

// Each input transfer carries one map; every map yields exactly one result
// transfer with the bounds after that map. One map is accepted per cycle
// while the pipeline is not held by a full output register; a map passes
// through the input register, the product stage, corner stage, min/max
// stage and output register in that order. The whole pipeline
// advances together whenever the output register is empty or its result is
// being taken, so in_tready follows out_tready combinationally and is low
// during reset; throughput is set by that single output register.
// Coordinates are signed Q35.28; corner sums clamp at the 64-bit limits.

module affine_rect_bounds_accumulator import arb_pkg::*; #(
  parameter int RECT_BITS = DEFAULT_RECT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // rect_x, rect_y, rect_w, rect_h, origin_x, x_per_col, x_per_row,
  // origin_y, y_per_col, y_per_row
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // first_map, visible
  input  logic [IN_USER_W-1:0]   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_left, out_right, out_top, out_bottom
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // any_seen, saturated
  output logic [OUT_USER_W-1:0]  out_tuser
);

  // Only the low bits of each rectangle field take part.
  localparam int USE_BITS = (RECT_BITS < RECT_FIELD_W) ? RECT_BITS : RECT_FIELD_W;
  localparam int CB       = USE_BITS + 1;

  // Payload offsets inside in_tdata.
  localparam int OFS_X  = 0;
  localparam int OFS_Y  = RECT_FIELD_W;
  localparam int OFS_W  = 2 * RECT_FIELD_W;
  localparam int OFS_H  = 3 * RECT_FIELD_W;
  localparam int OFS_OX = 4 * RECT_FIELD_W;
  localparam int OFS_XC = OFS_OX + COORD_W;
  localparam int OFS_XR = OFS_XC + COEF_W;
  localparam int OFS_OY = OFS_XR + COEF_W;
  localparam int OFS_YC = OFS_OY + COORD_W;
  localparam int OFS_YR = OFS_YC + COEF_W;

  logic                       en;
  logic                       v1_r, v2_r, v3_r, v4_r;
  arb_tag_t                   tag_in;
  arb_tag_t                   tag1_r, tag2_r, tag3_r, tag4_r;
  logic [CB-1:0]              col0_r, col1_r, row0_r, row1_r;
  logic signed [COORD_W-1:0]  ox_r, oy_r;
  logic signed [COEF_W-1:0]   xc_r, xr_r, yc_r, yr_r;
  logic signed [COORD_W-1:0]  gx [4];
  logic signed [COORD_W-1:0]  gy [4];
  logic                       csat;
  logic signed [COORD_W-1:0]  l_nxt, r_nxt, t_nxt, b_nxt;
  logic signed [COORD_W-1:0]  l4_r, r4_r, t4_r, b4_r;
  logic                       sat4_r;
  logic signed [COORD_W-1:0]  bound_left_r, bound_right_r, bound_top_r, bound_bottom_r;
  logic signed [COORD_W-1:0]  bound_left_nxt, bound_right_nxt;
  logic signed [COORD_W-1:0]  bound_top_nxt, bound_bottom_nxt;
  logic                       seen_r, seen_nxt, seen_base;
  logic                       out_valid_r;
  logic                       sat_out_r;

  // The pipeline moves as one whenever the output register can take data.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && rst_n;

  assign tag_in.first_map = in_tuser[IN_USER_FIRST];
  assign tag_in.visible   = in_tuser[IN_USER_VISIBLE];

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Input register: corner coordinates one bit wider so they never wrap.
  always_ff @(posedge clk) begin
    if (en) begin
      tag1_r <= tag_in;
      col0_r <= {1'b0, in_tdata[OFS_X +: USE_BITS]};
      col1_r <= {1'b0, in_tdata[OFS_X +: USE_BITS]} + {1'b0, in_tdata[OFS_W +: USE_BITS]};
      row0_r <= {1'b0, in_tdata[OFS_Y +: USE_BITS]};
      row1_r <= {1'b0, in_tdata[OFS_Y +: USE_BITS]} + {1'b0, in_tdata[OFS_H +: USE_BITS]};
      ox_r   <= in_tdata[OFS_OX +: COORD_W];
      xc_r   <= in_tdata[OFS_XC +: COEF_W];
      xr_r   <= in_tdata[OFS_XR +: COEF_W];
      oy_r   <= in_tdata[OFS_OY +: COORD_W];
      yc_r   <= in_tdata[OFS_YC +: COEF_W];
      yr_r   <= in_tdata[OFS_YR +: COEF_W];
    end
  end

  arb_corner_eval #(
    .CB (CB)
  ) u_corner (
    .clk       (clk),
    .en        (en),
    .col0      (col0_r),
    .col1      (col1_r),
    .row0      (row0_r),
    .row1      (row1_r),
    .origin_x  (ox_r),
    .x_per_col (xc_r),
    .x_per_row (xr_r),
    .origin_y  (oy_r),
    .y_per_col (yc_r),
    .y_per_row (yr_r),
    .gx        (gx),
    .gy        (gy),
    .sat       (csat)
  );

  // Tags follow the data through the corner unit.
  always_ff @(posedge clk) begin
    if (en) begin
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  // Extremes of the four corners, as a two-level compare tree.
  always_comb begin
    logic signed [COORD_W-1:0] la, lb, ra, rb, ta, tb, ba, bb;
    la = (gx[1] < gx[0]) ? gx[1] : gx[0];
    lb = (gx[3] < gx[2]) ? gx[3] : gx[2];
    ra = (gx[1] > gx[0]) ? gx[1] : gx[0];
    rb = (gx[3] > gx[2]) ? gx[3] : gx[2];
    ta = (gy[1] > gy[0]) ? gy[1] : gy[0];
    tb = (gy[3] > gy[2]) ? gy[3] : gy[2];
    ba = (gy[1] < gy[0]) ? gy[1] : gy[0];
    bb = (gy[3] < gy[2]) ? gy[3] : gy[2];
    l_nxt = (lb < la) ? lb : la;
    r_nxt = (rb > ra) ? rb : ra;
    t_nxt = (tb > ta) ? tb : ta;
    b_nxt = (bb < ba) ? bb : ba;
  end

  // Min/max stage register; an invisible map never reports saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      l4_r   <= l_nxt;
      r4_r   <= r_nxt;
      t4_r   <= t_nxt;
      b4_r   <= b_nxt;
      sat4_r <= csat && tag3_r.visible;
    end
  end

  // Running bounds: the first visible map of a set loads, later ones widen.
  always_comb begin
    seen_base        = seen_r && !tag4_r.first_map;
    seen_nxt         = seen_base || tag4_r.visible;
    bound_left_nxt   = bound_left_r;
    bound_right_nxt  = bound_right_r;
    bound_top_nxt    = bound_top_r;
    bound_bottom_nxt = bound_bottom_r;
    if (tag4_r.visible) begin
      if (!seen_base || l4_r < bound_left_r)   bound_left_nxt   = l4_r;
      if (!seen_base || r4_r > bound_right_r)  bound_right_nxt  = r4_r;
      if (!seen_base || t4_r > bound_top_r)    bound_top_nxt    = t4_r;
      if (!seen_base || b4_r < bound_bottom_r) bound_bottom_nxt = b4_r;
    end
  end

  // Bounds state doubles as the output register payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_left_r   <= '0;
      bound_right_r  <= '0;
      bound_top_r    <= '0;
      bound_bottom_r <= '0;
      seen_r         <= 1'b0;
      sat_out_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4_r;
      if (v4_r) begin
        bound_left_r   <= bound_left_nxt;
        bound_right_r  <= bound_right_nxt;
        bound_top_r    <= bound_top_nxt;
        bound_bottom_r <= bound_bottom_nxt;
        seen_r         <= seen_nxt;
        sat_out_r      <= sat4_r;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {bound_bottom_r, bound_top_r, bound_right_r, bound_left_r};
  assign out_tuser  = {sat_out_r, seen_r};

  // A clamped corner only comes from a visible map, which marks the set seen.
  a_sat_implies_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_USER_SAT] |-> out_tuser[OUT_USER_SEEN])
    else $error("saturated result without any visible map");

  // Once a visible map is in, the bounds are ordered.
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (bound_left_r <= bound_right_r) && (bound_bottom_r <= bound_top_r))
    else $error("bounds out of order");

  // A visible map leaving the last stage always sets the seen flag.
  a_visible_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
    en && v4_r && tag4_r.visible |=> seen_r)
    else $error("visible map did not set seen flag");

  // The bounds only move when a map reaches the output register.
  a_bounds_move_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    !(en && v4_r) |=> $stable(bound_left_r) && $stable(bound_top_r) && $stable(seen_r))
    else $error("bounds changed without a map");

endmodule
